[rtl/core/pfps_pkg.sv]
package pfps_pkg;

  localparam int VALUE_WIDTH = 32;
  // divisor never passes sqrt(2^(VALUE_WIDTH-1)) + 2
  localparam int D_W    = VALUE_WIDTH / 2 + 1;
  localparam int PROD_W = 2 * D_W;
  localparam int REM_W  = D_W + 1;
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

  typedef logic [2:0] step_t;

  localparam step_t P_WAIT    = 3'd0;
  localparam step_t P_TRIV    = 3'd1;
  localparam step_t P_SQUARE  = 3'd2;
  localparam step_t P_BOUND   = 3'd3;
  localparam step_t P_DIV     = 3'd4;
  localparam step_t P_REMCHK  = 3'd5;
  localparam step_t P_ADVANCE = 3'd6;
  localparam step_t P_EMIT    = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD, OP_TRIV, OP_SQUARE, OP_BOUND, OP_DIVSTEP, OP_REMCHK, OP_ADVANCE, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_NO_REQ, C_TRIV, C_OVER, C_DIV_BUSY, C_REM_ZERO, C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucw_t;

  // jump to target when cond holds, else fall through to the next step
  function automatic ucw_t ucode_rom(input step_t pc);
    ucw_t w;
    case (pc)
      P_WAIT:    w = '{op: OP_LOAD,    cond: C_NO_REQ,   target: P_WAIT};
      P_TRIV:    w = '{op: OP_TRIV,    cond: C_TRIV,     target: P_EMIT};
      P_SQUARE:  w = '{op: OP_SQUARE,  cond: C_ALWAYS,   target: P_BOUND};
      P_BOUND:   w = '{op: OP_BOUND,   cond: C_OVER,     target: P_EMIT};
      P_DIV:     w = '{op: OP_DIVSTEP, cond: C_DIV_BUSY, target: P_DIV};
      P_REMCHK:  w = '{op: OP_REMCHK,  cond: C_REM_ZERO, target: P_EMIT};
      P_ADVANCE: w = '{op: OP_ADVANCE, cond: C_ALWAYS,   target: P_SQUARE};
      P_EMIT:    w = '{op: OP_EMIT,    cond: C_OUT_BUSY, target: P_EMIT};
      default:   w = '{op: OP_LOAD,    cond: C_NO_REQ,   target: P_WAIT};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/pfps_if.sv]
interface pfps_in_if;
  import pfps_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          end_of_array;

  modport source (output valid, output value, output end_of_array, input ready);
  modport sink   (input valid, input value, input end_of_array, output ready);
endinterface

interface pfps_out_if;
  import pfps_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          is_prime;
  logic signed [VALUE_WIDTH-1:0] prime_value;
  logic                          is_odd;
  logic                          last;

  modport source (output valid, output is_prime, output prime_value, output is_odd,
                  output last, input ready);
  modport sink   (input valid, input is_prime, input prime_value, input is_odd,
                  input last, output ready);
endinterface

[rtl/core/prime_filter_parity_split.sv]
// channel   | dir | handshake    | payload
// in_chan   | in  | valid/ready  | value[31:0] signed, end_of_array
// out_chan  | out | valid/ready  | is_prime, prime_value[31:0] signed, is_odd, last
//
// One request at a time, run by an 8-step microprogram over one divider.
// Negative, below 3 or even values skip the divider: trivial test, then the emit step.
// Otherwise odd divisors from 3 are tried in turn; each costs a
// square, a bound compare, 32 restoring divide steps, a remainder test, an increment.
// A large prime is the worst case: the bit-serial divider runs for every odd divisor.
// rst_n is synchronous; it clears the step counter and the output valid.
// A held result stalls the emit step, and so acceptance of the next request, until taken.
module prime_filter_parity_split (
  input logic clk,
  input logic rst_n,
  pfps_in_if.sink    in_chan,
  pfps_out_if.source out_chan
);
  import pfps_pkg::*;

  step_t                   pc_r, pc_nxt;
  ucw_t                    cw;
  logic                    cond_hit;
  logic                    accept;
  logic                    out_busy;
  logic                    trivial;

  logic [VALUE_WIDTH-1:0]  v_r;
  logic                    last_r;
  logic                    prime_r;
  logic [D_W-1:0]          d_r;
  logic [PROD_W-1:0]       sq_r;
  logic [REM_W-1:0]        rem_r, rem_nxt, trial;
  logic [VALUE_WIDTH-1:0]  sh_r;
  logic [CNT_W-1:0]        cnt_r;

  logic                    out_valid_r;
  logic                    out_prime_r;
  logic [VALUE_WIDTH-1:0]  out_value_r;
  logic                    out_last_r;

  assign cw       = ucode_rom(pc_r);
  assign accept   = in_chan.valid && in_chan.ready;
  assign out_busy = out_valid_r && !out_chan.ready;
  assign trivial  = v_r[VALUE_WIDTH-1] || (v_r < VALUE_WIDTH'(3)) || !v_r[0];

  assign trial = {rem_r[REM_W-2:0], sh_r[VALUE_WIDTH-1]};
  always_comb begin
    if (trial >= REM_W'(d_r)) begin
      rem_nxt = trial - REM_W'(d_r);
    end else begin
      rem_nxt = trial;
    end
  end

  always_comb begin
    case (cw.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_NO_REQ:   cond_hit = !accept;
      C_TRIV:     cond_hit = trivial;
      C_OVER:     cond_hit = sq_r > PROD_W'(v_r);
      C_DIV_BUSY: cond_hit = cnt_r != CNT_W'(1);
      C_REM_ZERO: cond_hit = rem_r == '0;
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
    // falling through from the last step wraps to the wait step
    pc_nxt = cond_hit ? cw.target : pc_r + step_t'(1);
  end

  assign in_chan.ready = (cw.op == OP_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= P_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cw.op == OP_EMIT && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (accept) begin
          v_r    <= in_chan.value;
          last_r <= in_chan.end_of_array;
        end
      end
      OP_TRIV: begin
        prime_r <= (v_r == VALUE_WIDTH'(2));
        d_r     <= D_W'(3);
      end
      OP_SQUARE: sq_r <= PROD_W'(d_r) * PROD_W'(d_r);
      OP_BOUND: begin
        prime_r <= 1'b1;
        rem_r   <= '0;
        sh_r    <= v_r;
        cnt_r   <= CNT_W'(VALUE_WIDTH);
      end
      OP_DIVSTEP: begin
        rem_r <= rem_nxt;
        sh_r  <= sh_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      OP_REMCHK:  prime_r <= 1'b0;
      OP_ADVANCE: d_r <= d_r + D_W'(2);
      OP_EMIT: begin
        if (!out_busy) begin
          out_prime_r <= prime_r;
          out_value_r <= v_r;
          out_last_r  <= last_r;
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.is_prime    = out_prime_r;
  assign out_chan.prime_value = $signed(out_value_r);
  assign out_chan.is_odd      = out_value_r[0];
  assign out_chan.last        = out_last_r;

  a_accept_to_triv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (pc_r == P_TRIV))
    else $error("accepted request did not start the test");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == P_REMCHK) |-> (rem_r < REM_W'(d_r)))
    else $error("remainder not below divisor");

  a_prime_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_prime_r) |-> !out_value_r[VALUE_WIDTH-1])
    else $error("negative value flagged prime");

  a_prime_odd_or_two: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_prime_r) |-> (out_value_r[0] || out_value_r == VALUE_WIDTH'(2)))
    else $error("even value other than two flagged prime");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pc_r) == P_EMIT))
    else $error("result raised outside the emit step");

endmodule

[tb/prime_filter_parity_split_test.sv]
`timescale 1ns / 1ps

module prime_filter_parity_split_test;
  import pfps_pkg::*;

  localparam int N_DIR      = 20;
  localparam int N_RAND     = 80;
  localparam int IDLE_PCT   = 27;
  localparam int HOLD_LEN   = 300;
  localparam int QUIET_MAX  = 5_000_000;
  localparam int STEADY_LO  = N_DIR + 35;
  localparam int STEADY_HI  = N_DIR + 60;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // one request; known = 1 when the verdict is typed in the table
  typedef struct packed {
    value_t value;
    logic   eoa;
    logic   known;
    logic   k_prime;
    logic   k_odd;
  } candidate_t;

  typedef struct packed {
    logic   is_prime;
    value_t prime_value;
    logic   is_odd;
    logic   last;
  } verdict_t;

  logic clk;
  logic rst_n;

  pfps_in_if  in_chan ();
  pfps_out_if out_chan ();

  prime_filter_parity_split dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  candidate_t candidates[$];
  candidate_t directed_tab [N_DIR];
  verdict_t   pending_verdicts[$];

  int n_total;
  int n_acc;
  int n_res;
  int mismatches;
  int quiet_cycles;
  int next_idx;
  int shown_idx;
  logic hold_rx;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.value     = '0;
    in_chan.end_of_array = 1'b0;
    out_chan.ready    = 1'b0;
    hold_rx           = 1'b0;
    n_acc             = 0;
    n_res             = 0;
    mismatches        = 0;
    quiet_cycles      = 0;
    next_idx          = 0;
    shown_idx         = 0;
  end

  function automatic logic is_prime_trial(input value_t v);
    longint unsigned u;
    longint unsigned d;
    if (v < 2) return 1'b0;
    u = longint'(v);
    if (u == 2) return 1'b1;
    if (u[0] == 1'b0) return 1'b0;
    for (d = 3; d <= u / d; d += 2) begin
      if (u % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t predict_verdict(input candidate_t c);
    verdict_t r;
    r.prime_value = c.value;
    r.last        = c.eoa;
    if (c.known) begin
      r.is_prime = c.k_prime;
      r.is_odd   = c.k_odd;
    end else begin
      r.is_prime = is_prime_trial(c.value);
      r.is_odd   = c.value[0];
    end
    return r;
  endfunction

  function automatic candidate_t random_candidate();
    candidate_t  c;
    int unsigned pick;
    int unsigned q;
    value_t      v;
    pick = $urandom_range(99);
    v    = value_t'($urandom);
    if (pick < 30) begin
      v = value_t'($urandom_range(4095, 0));
    end else if (pick < 45) begin
      v = value_t'($urandom_range(16383, 2));
      v[0] = 1'b1;
    end else if (pick < 65) begin
      v[VALUE_WIDTH-1] = 1'b1;
    end else if (pick < 80) begin
      v[VALUE_WIDTH-1] = 1'b0;
      v[0] = 1'b0;
    end else if (pick < 95) begin
      // large but with a factor of 3, so the divider loop ends at once
      v = value_t'($urandom_range(32'd715827882, 1) * 3);
    end else begin
      // odd squares hit the d*d == v bound
      q = 2 * $urandom_range(90, 1) + 1;
      v = value_t'(q * q);
    end
    c.value   = v;
    c.eoa     = ($urandom_range(7) == 0);
    c.known   = 1'b0;
    c.k_prime = 1'b0;
    c.k_odd   = 1'b0;
    return c;
  endfunction

  // request side
  always @(posedge clk) begin : drive_requests
    logic fire;
    logic idle;
    logic gate;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      fire = in_chan.valid && in_chan.ready;
      if (fire) begin
        pending_verdicts.push_back(predict_verdict(candidates[shown_idx]));
        n_acc <= n_acc + 1;
      end
      if (!in_chan.valid || fire) begin
        idle = (next_idx >= STEADY_LO && next_idx < STEADY_HI) ? 1'b0 :
               ($urandom_range(99) < IDLE_PCT);
        // sender waits for the block to drain before the random part
        gate = (next_idx == N_DIR) && (fire || n_acc != n_res);
        if (next_idx < n_total && !gate && !idle) begin
          in_chan.valid        <= 1'b1;
          in_chan.value        <= candidates[next_idx].value;
          in_chan.end_of_array <= candidates[next_idx].eoa;
          shown_idx = next_idx;
          next_idx  = next_idx + 1;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= !hold_rx &&
                        ((n_res >= STEADY_LO && n_res < STEADY_HI) ||
                         ($urandom_range(99) >= IDLE_PCT));
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (n_acc >= N_DIR + 10);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t exp_v;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_res <= n_res + 1;
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: value %0d prime %b odd %b last %b",
                   out_chan.prime_value, out_chan.is_prime, out_chan.is_odd, out_chan.last);
        mismatches++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_chan.is_prime !== exp_v.is_prime || out_chan.prime_value !== exp_v.prime_value ||
            out_chan.is_odd !== exp_v.is_odd || out_chan.last !== exp_v.last) begin
          if (mismatches < 10)
            $display("mismatch: exp value %0d prime %b odd %b last %b, got %0d %b %b %b",
                     exp_v.prime_value, exp_v.is_prime, exp_v.is_odd, exp_v.last,
                     out_chan.prime_value, out_chan.is_prime, out_chan.is_odd, out_chan.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // value, end_of_array, known, prime, odd
    directed_tab = '{
      '{32'sh8000_0000, 1'b0, 1'b1, 1'b0, 1'b0},
      '{-32'sd1,        1'b1, 1'b1, 1'b0, 1'b1},
      '{32'sd0,         1'b0, 1'b1, 1'b0, 1'b0},
      '{32'sd1,         1'b0, 1'b1, 1'b0, 1'b1},
      '{32'sd2,         1'b0, 1'b1, 1'b1, 1'b0},
      '{32'sd3,         1'b1, 1'b1, 1'b1, 1'b1},
      '{32'sd4,         1'b0, 1'b1, 1'b0, 1'b0},
      '{32'sh7fff_ffff, 1'b1, 1'b1, 1'b1, 1'b1},
      '{32'sh7fff_fffe, 1'b0, 1'b1, 1'b0, 1'b0},
      '{-32'sd3,        1'b0, 1'b0, 1'b0, 1'b0},
      '{32'sd9,         1'b0, 1'b0, 1'b0, 1'b0},
      '{32'sd25,        1'b1, 1'b0, 1'b0, 1'b0},
      '{32'sd49,        1'b0, 1'b0, 1'b0, 1'b0},
      '{32'sd121,       1'b0, 1'b0, 1'b0, 1'b0},
      '{32'sd97,        1'b0, 1'b0, 1'b0, 1'b0},
      '{32'sd65537,     1'b1, 1'b0, 1'b0, 1'b0},
      '{32'sd1000003,   1'b0, 1'b0, 1'b0, 1'b0},
      '{32'sh7fff_fffd, 1'b0, 1'b0, 1'b0, 1'b0},
      '{32'sh8000_0001, 1'b1, 1'b0, 1'b0, 1'b0},
      '{32'sh4000_0000, 1'b0, 1'b0, 1'b0, 1'b0}
    };
    for (int i = 0; i < N_DIR; i++) candidates.push_back(directed_tab[i]);
    for (int i = 0; i < N_RAND; i++) candidates.push_back(random_candidate());
    n_total = candidates.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_acc == n_total);
    wait (n_res == n_acc);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
